### rtl/wis_pkg.sv
`default_nettype none

package wis_pkg;

  localparam int SECS_W   = 22;
  localparam int DELAY_W  = 17;
  localparam int PERIOD_W = 16;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int WINLEN_W = 11;
  localparam int SEED_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ALU_W    = SECS_W + 1;
  localparam int SEED_IDX_W = $clog2(SEED_W);

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ARM  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HOUR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MINUTE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LENGTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_SEED   = 3'd5;

  typedef struct packed {
    logic                req_type;
    logic [HOUR_W-1:0]   clock_hour;
    logic [MINUTE_W-1:0] clock_minute;
  } req_t;

  typedef struct packed {
    logic sample_wake;
    logic report_wake;
    logic window_armed;
  } rsp_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] sample_period_min;
    logic [PERIOD_W-1:0] report_period_min;
    logic [HOUR_W-1:0]   window_start_hour;
    logic [MINUTE_W-1:0] window_start_minute;
    logic [WINLEN_W-1:0] window_length_min;
    logic [SEED_W-1:0]   spread_seed;
  } cfg_t;

  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

  // minutes to seconds: x*64 - x*4
  function automatic logic [SECS_W-1:0] to_seconds(input logic [PERIOD_W-1:0] minutes);
    logic [SECS_W-1:0] x;
    x = {{(SECS_W-PERIOD_W){1'b0}}, minutes};
    return (x << 6) - (x << 2);
  endfunction

endpackage

`default_nettype wire

### rtl/wis_alu.sv
`default_nettype none

module wis_alu
  import wis_pkg::*;
(
  input  wire logic [ALU_W-1:0] a,
  input  wire logic [ALU_W-1:0] b,
  output alu_res_t              res
);

  logic [ALU_W:0] wide;

  // one subtractor, borrow out gives the compare
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[ALU_W-1:0];
  assign res.ge   = ~wide[ALU_W];

endmodule

`default_nettype wire

### rtl/wis_core.sv
`default_nettype none

module wis_core
  import wis_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req_data,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SAMPLE = 6'b000010,
    S_REPORT = 6'b000100,
    S_DRAW   = 6'b001000,
    S_DELAY  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [SECS_W-1:0]     sample_seconds;
  logic [SECS_W-1:0]     report_seconds;
  logic [DELAY_W-1:0]    delay_target;
  logic [DELAY_W-1:0]    delay_seconds;
  logic                  armed_flag;

  req_t                  hold;
  logic [DELAY_W-1:0]    rem;
  logic [SEED_IDX_W-1:0] bit_idx;
  logic                  s_wake;
  logic                  r_wake;

  logic [SECS_W-1:0]     sample_inc;
  logic [SECS_W-1:0]     report_inc;
  logic [DELAY_W-1:0]    delay_inc;
  logic [SECS_W-1:0]     sample_limit;
  logic [SECS_W-1:0]     report_limit;
  logic [SECS_W-1:0]     span_full;
  logic [DELAY_W-1:0]    span;
  logic [DELAY_W:0]      partial;
  logic [DELAY_W-1:0]    rem_next;
  logic                  win_match;

  logic [ALU_W-1:0]      alu_a;
  logic [ALU_W-1:0]      alu_b;
  alu_res_t              alu;

  assign sample_inc   = sample_seconds + SECS_W'(1);
  assign report_inc   = report_seconds + SECS_W'(1);
  assign delay_inc    = delay_seconds + DELAY_W'(1);
  assign sample_limit = to_seconds(cfg.sample_period_min);
  assign report_limit = to_seconds(cfg.report_period_min);
  assign span_full    = to_seconds({{(PERIOD_W-WINLEN_W){1'b0}}, cfg.window_length_min});
  assign span         = span_full[DELAY_W-1:0];
  assign partial      = {rem, cfg.spread_seed[bit_idx]};
  assign rem_next     = alu.ge ? alu.diff[DELAY_W-1:0] : partial[DELAY_W-1:0];
  assign win_match    = (hold.clock_hour == cfg.window_start_hour) &&
                        (hold.clock_minute == cfg.window_start_minute);

  assign req_ready = (state == S_IDLE);

  // operand select for the shared subtractor
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      S_SAMPLE: begin
        alu_a = {1'b0, sample_inc};
        alu_b = {1'b0, sample_limit};
      end
      S_REPORT: begin
        alu_a = {1'b0, report_inc};
        alu_b = {1'b0, report_limit};
      end
      S_DRAW: begin
        alu_a = {{(ALU_W-DELAY_W-1){1'b0}}, partial};
        alu_b = {{(ALU_W-DELAY_W){1'b0}}, span};
      end
      S_DELAY: begin
        alu_a = {{(ALU_W-DELAY_W){1'b0}}, delay_inc};
        alu_b = {{(ALU_W-DELAY_W){1'b0}}, delay_target};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  wis_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      sample_seconds <= '0;
      report_seconds <= '0;
      delay_target   <= '0;
      delay_seconds  <= '0;
      armed_flag     <= 1'b0;
    end else begin
      if (rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            hold   <= req_data;
            s_wake <= 1'b0;
            r_wake <= 1'b0;
            if (req_data.req_type == REQ_ARM) begin
              armed_flag <= 1'b1;
              state      <= S_DONE;
            end else begin
              state <= S_SAMPLE;
            end
          end
        end
        S_SAMPLE: begin
          if (cfg.sample_period_min != '0) begin
            if (alu.ge) begin
              sample_seconds <= '0;
              s_wake         <= 1'b1;
            end else begin
              sample_seconds <= sample_inc;
            end
          end
          if (!armed_flag) begin
            state <= S_REPORT;
          end else if (delay_target == '0) begin
            if (win_match && span == '0) begin
              delay_target <= DELAY_W'(1);
              state        <= S_DONE;
            end else if (win_match) begin
              rem     <= '0;
              bit_idx <= SEED_IDX_W'(SEED_W - 1);
              state   <= S_DRAW;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DELAY;
          end
        end
        S_REPORT: begin
          if (cfg.report_period_min != '0) begin
            if (alu.ge) begin
              report_seconds <= '0;
              r_wake         <= 1'b1;
            end else begin
              report_seconds <= report_inc;
            end
          end
          state <= S_DONE;
        end
        S_DRAW: begin
          // restoring remainder, one seed bit a cycle, msb first
          rem <= rem_next;
          if (bit_idx == '0) begin
            delay_target <= rem_next + DELAY_W'(1);
            state        <= S_DONE;
          end else begin
            bit_idx <= bit_idx - SEED_IDX_W'(1);
          end
        end
        S_DELAY: begin
          if (alu.ge) begin
            armed_flag     <= 1'b0;
            delay_target   <= '0;
            delay_seconds  <= '0;
            report_seconds <= '0;
            r_wake         <= 1'b1;
          end else begin
            delay_seconds <= delay_inc;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid             <= 1'b1;
            rsp_data.sample_wake  <= s_wake;
            rsp_data.report_wake  <= r_wake;
            rsp_data.window_armed <= armed_flag;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_target_needs_arm: assert property (@(posedge clk) disable iff (rst)
    !armed_flag |-> delay_target == '0)
    else $error("delay target drawn while no window armed");

  a_idle_delay_clear: assert property (@(posedge clk) disable iff (rst)
    delay_target == '0 |-> delay_seconds == '0)
    else $error("delay count running with no target");

  a_delay_below_target: assert property (@(posedge clk) disable iff (rst)
    delay_target != '0 |-> delay_seconds < delay_target)
    else $error("delay count passed its target");

  a_draw_nonzero_span: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAW |-> span != '0)
    else $error("remainder sweep with empty window");

endmodule

`default_nettype wire

### rtl/wake_interval_scheduler.sv
`default_nettype none

// wake interval scheduler: each req beat is either a one-second tick or a
// request to arm the discrete report window; each one yields exactly one rsp
// beat with sample_wake, report_wake and window_armed. an arm beat goes
// straight to S_DONE; a tick passes S_SAMPLE, then as needed one of
// S_REPORT, S_DELAY or S_DRAW, then S_DONE. S_DRAW is the bit-a-cycle
// remainder (spread_seed mod window_length_min*60) run on the single
// shared subtractor, which also does every period and delay compare.
// rsp_valid rises as S_DONE loads the rsp register and req_ready comes
// back at that same edge, so one beat is worked at a time. req_ready
// is low while an item is being worked on; a finished result sits in the rsp
// register so the next beat can be taken before it drains, and a second
// finished result waits until the first is taken. registers are written
// through cfg_we/cfg_index/cfg_data and should only change while the block
// is idle.
module wake_interval_scheduler
  import wis_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire req_t                 req_data,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_t                      rsp_data
);

  // register file, all zero after reset
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: cfg.sample_period_min   <= cfg_data[PERIOD_W-1:0];
        REG_REPORT_PERIOD: cfg.report_period_min   <= cfg_data[PERIOD_W-1:0];
        REG_WIN_HOUR:      cfg.window_start_hour   <= cfg_data[HOUR_W-1:0];
        REG_WIN_MINUTE:    cfg.window_start_minute <= cfg_data[MINUTE_W-1:0];
        REG_WIN_LENGTH:    cfg.window_length_min   <= cfg_data[WINLEN_W-1:0];
        REG_SPREAD_SEED:   cfg.spread_seed         <= cfg_data[SEED_W-1:0];
        // unmapped indexes are dropped
        default: begin
        end
      endcase
    end
  end

  // sequencer, counters and the shared subtractor
  wis_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

### sim/wake_interval_scheduler_tb.sv
`default_nettype none

module wake_interval_scheduler_tb;
  import wis_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 30;

  // predicted scheduler state plus the queue of wake results still owed
  class wake_scoreboard;
    logic [PERIOD_W-1:0] sample_period;
    logic [PERIOD_W-1:0] report_period;
    logic [HOUR_W-1:0]   win_hour;
    logic [MINUTE_W-1:0] win_minute;
    logic [WINLEN_W-1:0] win_len;
    logic [SEED_W-1:0]   seed;
    logic [SECS_W-1:0]   sample_secs;
    logic [SECS_W-1:0]   report_secs;
    logic [DELAY_W-1:0]  delay_target;
    logic [DELAY_W-1:0]  delay_secs;
    logic                armed;
    rsp_t                expected_wakes[$];
    int                  mismatches;

    function new();
      sample_period = '0;
      report_period = '0;
      win_hour      = '0;
      win_minute    = '0;
      win_len       = '0;
      seed          = '0;
      sample_secs   = '0;
      report_secs   = '0;
      delay_target  = '0;
      delay_secs    = '0;
      armed         = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SAMPLE_PERIOD: sample_period = val[PERIOD_W-1:0];
        REG_REPORT_PERIOD: report_period = val[PERIOD_W-1:0];
        REG_WIN_HOUR:      win_hour      = val[HOUR_W-1:0];
        REG_WIN_MINUTE:    win_minute    = val[MINUTE_W-1:0];
        REG_WIN_LENGTH:    win_len       = val[WINLEN_W-1:0];
        REG_SPREAD_SEED:   seed          = val[SEED_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_req(req_t r);
      rsp_t        e;
      int unsigned secs;
      int unsigned period;
      int unsigned span;
      int unsigned rem;
      e = '0;
      if (r.req_type == REQ_ARM) begin
        armed = 1'b1;
      end else begin
        if (sample_period != 0) begin
          sample_secs = sample_secs + 1'b1;
          secs = 32'(sample_secs);
          period = 32'(sample_period);
          if (secs / 60 >= period) begin
            sample_secs = '0;
            e.sample_wake = 1'b1;
          end
        end
        if (!armed) begin
          if (report_period != 0) begin
            report_secs = report_secs + 1'b1;
            secs = 32'(report_secs);
            period = 32'(report_period);
            if (secs / 60 >= period) begin
              report_secs = '0;
              e.report_wake = 1'b1;
            end
          end
        end else if (delay_target == 0) begin
          // draw tick: only computes the delay, no countdown yet
          if (r.clock_hour == win_hour && r.clock_minute == win_minute) begin
            span = 32'(win_len);
            span = span * 60;
            rem = 32'(seed);
            rem = (span == 0) ? 0 : rem % span;
            delay_target = DELAY_W'(rem + 1);
          end
        end else begin
          delay_secs = delay_secs + 1'b1;
          if (delay_secs >= delay_target) begin
            armed        = 1'b0;
            delay_target = '0;
            delay_secs   = '0;
            report_secs  = '0;
            e.report_wake = 1'b1;
          end
        end
      end
      e.window_armed = armed;
      expected_wakes.push_back(e);
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t e;
      if (expected_wakes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected rsp beat: sample=%b report=%b armed=%b",
                   got.sample_wake, got.report_wake, got.window_armed);
        return;
      end
      e = expected_wakes.pop_front();
      if (got.sample_wake !== e.sample_wake || got.report_wake !== e.report_wake ||
          got.window_armed !== e.window_armed) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"rsp mismatch: exp sample=%b report=%b armed=%b, ",
                    "got sample=%b report=%b armed=%b"},
                   e.sample_wake, e.report_wake, e.window_armed,
                   got.sample_wake, got.report_wake, got.window_armed);
      end
    endfunction

    function int pending();
      return expected_wakes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 req_valid;
  logic                 req_ready;
  req_t                 req_data;
  logic                 rsp_valid;
  logic                 rsp_ready;
  rsp_t                 rsp_data;

  wake_scoreboard sb;
  int             items_sent;
  int             burst_left;
  int             cycles;
  bit             hold_request;

  // tb-side copies of the window setup, used to size the countdown runs
  logic [WINLEN_W-1:0] cur_len;
  logic [SEED_W-1:0]   cur_seed;
  logic [HOUR_W-1:0]   cur_hour;
  logic [MINUTE_W-1:0] cur_minute;

  wake_interval_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // every accepted rsp beat goes straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      sb.check_rsp(rsp_data);
  end

  // receiver: runs of always-ready, coin-flip and mostly-stalled, plus the
  // long hold-off the sender asks for once
  initial begin
    int mode;
    int run_left;
    mode = 0;
    run_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (run_left == 0) begin
        mode = $urandom_range(0, 2);
        run_left = $urandom_range(5, 60);
      end
      run_left--;
      case (mode)
        0: rsp_ready = 1'b1;
        1: rsp_ready = 1'($urandom_range(0, 1));
        default: rsp_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offer one req beat, hold it until taken, then maybe open a gap
  task automatic offer(input req_t r);
    req_valid = 1'b1;
    req_data  = r;
    do @(posedge clk); while (!req_ready);
    sb.note_req(r);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic tick(input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] m);
    req_t r;
    r.req_type     = REQ_TICK;
    r.clock_hour   = h;
    r.clock_minute = m;
    offer(r);
  endtask

  task automatic random_tick();
    tick(HOUR_W'($urandom_range(0, 31)), MINUTE_W'($urandom_range(0, 63)));
  endtask

  task automatic arm();
    req_t r;
    r.req_type     = REQ_ARM;
    r.clock_hour   = HOUR_W'($urandom_range(0, 31));
    r.clock_minute = MINUTE_W'($urandom_range(0, 63));
    offer(r);
  endtask

  // stop offering until every owed result has drained, then let it settle
  task automatic drain();
    req_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [15:0] sp, input logic [15:0] rp,
                           input logic [4:0] h, input logic [5:0] m,
                           input logic [10:0] len, input logic [15:0] seed);
    write_reg(REG_SAMPLE_PERIOD, sp);
    write_reg(REG_REPORT_PERIOD, rp);
    write_reg(REG_WIN_HOUR, CFG_W'(h));
    write_reg(REG_WIN_MINUTE, CFG_W'(m));
    write_reg(REG_WIN_LENGTH, CFG_W'(len));
    write_reg(REG_SPREAD_SEED, seed);
    cur_hour   = h;
    cur_minute = m;
    cur_len    = len;
    cur_seed   = seed;
  endtask

  // well-formed window: arm, a few stray ticks, the start tick, then the
  // countdown with the odd redundant arm mixed in
  task automatic window_run();
    int unsigned span;
    int unsigned delay;
    int          n;
    span = 32'(cur_len);
    span = span * 60;
    delay = 32'(cur_seed);
    delay = (span == 0) ? 1 : (delay % span) + 1;
    arm();
    repeat ($urandom_range(0, 3)) random_tick();
    tick(cur_hour, cur_minute);
    n = delay + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) arm();
      random_tick();
    end
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd3;
      4: return 16'hFFFF;
      default: return 16'd1;
    endcase
  endfunction

  initial begin
    logic [15:0] sp;
    logic [15:0] rp;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [10:0] len;
    logic [15:0] seed;
    int          phase_start;
    int          pick;
    bit          held;
    bit          paused;

    sb = new();
    items_sent   = 0;
    burst_left   = 1;
    hold_request = 1'b0;
    held         = 1'b0;
    paused       = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    req_valid = 1'b0;
    req_data  = '0;
    cur_hour   = '0;
    cur_minute = '0;
    cur_len    = '0;
    cur_seed   = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // registers at reset: zero periods hold both counters, arm twice,
    // zero-length window gives a one second delay
    tick(5'd0, 6'd0);
    arm();
    arm();
    tick(5'd0, 6'd0);
    tick(5'd31, 6'd63);
    tick(5'd31, 6'd63);
    drain();

    // out-of-range start time, widest window with a small seed
    configure(16'd1, 16'hFFFF, 5'd31, 6'd63, 11'd1440, 16'd3);
    arm();
    tick(5'd0, 6'd0);
    tick(5'd31, 6'd63);
    repeat (4) tick(5'd31, 6'd63);
    drain();

    // largest seed with a one-minute window
    configure(16'd0, 16'd1, 5'd12, 6'd30, 11'd1, 16'hFFFF);
    arm();
    tick(5'd12, 6'd30);
    repeat (16) random_tick();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      sp   = pick_period();
      rp   = pick_period();
      h    = HOUR_W'($urandom_range(0, 31));
      m    = MINUTE_W'($urandom_range(0, 63));
      seed = SEED_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0, 1: len = WINLEN_W'($urandom_range(0, 3));
        2: begin
          len  = WINLEN_W'($urandom_range(1000, 1440));
          seed = SEED_W'($urandom_range(0, 150));
        end
        default: len = 11'd0;
      endcase
      if (p == 0) begin
        sp = 16'hFFFF; rp = 16'hFFFF; h = 5'd23; m = 6'd59; len = 11'd1440;
        seed = SEED_W'($urandom_range(0, 150));
      end else if (p == 1) begin
        sp = 16'd0; rp = 16'd0; h = 5'd0; m = 6'd0; len = 11'd0; seed = 16'd0;
      end else if (p == NUM_PHASES - 1) begin
        // seed at its top with 65520 seconds of window: delay of 16
        sp = 16'd1; rp = 16'd2; len = 11'd1092; seed = 16'hFFFF;
      end
      configure(sp, rp, h, m, len, seed);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (p == 2 && !held) begin
          hold_request = 1'b1;
          held = 1'b1;
        end
        if (p == 4 && !paused && items_sent - phase_start > 40) begin
          req_valid = 1'b0;
          while (sb.pending() != 0) @(negedge clk);
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          window_run();
        end else if (pick < 80) begin
          repeat ($urandom_range(10, 90)) random_tick();
        end else begin
          // noise: loose arms and ticks, sometimes an arm left dangling
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 3) == 0) arm();
            else random_tick();
          end
        end
      end
      drain();
    end

    req_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
